/* src/rspc_pkg.sv */
// ----------------------------------------------------------------------------
// rspc_pkg
// Shared types and fixed widths for the residue shortest path reach counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rspc_pkg;

  localparam int LW = 60;  // limit and count width
  localparam int MW = 18;  // step width
  localparam int DW = 64;  // least reachable value width

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DIV,
    S_SEED,
    S_POP,
    S_POPW,
    S_LOADF,
    S_EDGE_RD,
    S_EDGE_WR,
    S_SUM,
    S_DRAIN,
    S_RESULT
  } rspc_state_t;

  typedef enum logic [1:0] {
    DIV_E1,
    DIV_E2,
    DIV_LIM,
    DIV_FIN
  } rspc_div_op_t;

endpackage

`default_nettype wire

/* src/residue_shortest_path_reach_count.sv */
// ----------------------------------------------------------------------------
// residue_shortest_path_reach_count
// Counts values 1..limit that are 1 plus a nonnegative combination of three
// steps, by a shortest path search over the residues of the smallest step.
// ----------------------------------------------------------------------------
// Usage:
//   A request (limit, step_one, step_two, step_three) is taken when in_valid
//   is high and in_stall is low. One reach_count result per request leaves
//   on out_valid/out_stall; the result register holds while out_stall is high.
//   One request is worked at a time; in_stall stays high from acceptance until
//   the result is loaded into the output register.
//   With m the smallest step, a request passes from acceptance to out_valid
//   through a clearing pass over m entries, three shift-subtract divisions
//   (steps and limit modulo m), the queue relaxation (for each pop a queue
//   read, a least value load, then a read and a write for each edge through
//   one port on each memory), a summing pass over m entries and one final
//   division. A zero step or m above RESIDUE_MAX skips these and gives 0.
//   Reset returns to idle and drops out_valid; the residue memories are
//   cleared per request, so reset needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module residue_shortest_path_reach_count #(
  parameter int RESIDUE_MAX = 131072
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [rspc_pkg::LW-1:0] limit,
  input  logic [rspc_pkg::MW-1:0] step_one,
  input  logic [rspc_pkg::MW-1:0] step_two,
  input  logic [rspc_pkg::MW-1:0] step_three,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [rspc_pkg::LW-1:0] reach_count
);

  import rspc_pkg::*;

  localparam int AW  = $clog2(RESIDUE_MAX);
  localparam int DVW = LW + AW + 1;
  localparam int RW  = 2 * AW + 1;
  localparam int DCW = $clog2(DVW + 1);

  rspc_state_t  state, state_next;
  rspc_div_op_t div_op;

  logic [MW-1:0]   m, e1, e2;
  logic [LW-1:0]   lim;
  logic [AW:0]     m_w;
  logic [AW-1:0]   m_last, e1m, e2m, lm;
  logic [AW-1:0]   sweep, head, tail, f, to_r;
  logic [AW:0]     qcnt;
  logic [DW-1:0]   dist_f, cand_r;
  logic            edge_sel;
  logic            s1_v, s2_v, s2_hit;
  logic [AW-1:0]   s1_r, s2_rem;
  logic [LW-1:0]   s2_diff, total;
  logic [AW:0]     acc_cnt;
  logic [DVW-1:0]  acc_s, div_quo, quo_next;
  logic [RW-1:0]   acc_r;
  logic [MW-1:0]   div_rem, rem_next;
  logic [DCW-1:0]  div_cnt;

  // request sort
  logic [MW-1:0] sa, sb, sc, sb1, sc1, smin;
  logic          refuse;

  // memory ports
  logic            lr_we, lr_re, fl_we, fl_wdata, fl_re, q_we, q_re;
  logic [AW-1:0]   lr_waddr, lr_raddr, fl_waddr, fl_raddr, q_waddr, q_raddr, q_wdata;
  logic [DW-1:0]   lr_wdata, lr_rdata;
  logic            fl_rdata;
  logic [AW-1:0]   q_rdata;

  // datapath helpers
  logic [MW:0]     trial;
  logic            div_ge, div_last;
  logic [AW-1:0]   em, to, r0;
  logic [MW-1:0]   estep;
  logic [AW:0]     sum_to, lmx, rx;
  logic            upd, enq, sweep_end;
  logic [AW-1:0]   tail_inc, head_inc;

  rspc_ram #(.WIDTH(DW), .DEPTH(RESIDUE_MAX)) u_least (
    .clk(clk), .we(lr_we), .waddr(lr_waddr), .wdata(lr_wdata),
    .re(lr_re), .raddr(lr_raddr), .rdata(lr_rdata)
  );

  rspc_ram #(.WIDTH(1), .DEPTH(RESIDUE_MAX)) u_flag (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .re(fl_re), .raddr(fl_raddr), .rdata(fl_rdata)
  );

  rspc_ram #(.WIDTH(AW), .DEPTH(RESIDUE_MAX)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  // Smallest step becomes the modulus.
  always_comb begin
    sa  = step_one;
    sb  = step_two;
    sc  = step_three;
    sb1 = sb;
    if (sb < sa) begin
      sb1 = sa;
      sa  = sb;
    end
    sc1 = sc;
    smin = sa;
    if (sc < sa) begin
      sc1  = sa;
      smin = sc;
    end
    refuse = (step_one == '0) || (step_two == '0) || (step_three == '0) ||
             (32'(smin) > RESIDUE_MAX);
  end

  // Shift-subtract divider, one quotient bit a cycle.
  assign trial    = {div_rem, div_quo[DVW-1]};
  assign div_ge   = trial >= {1'b0, m};
  assign rem_next = div_ge ? MW'(trial - {1'b0, m}) : trial[MW-1:0];
  assign quo_next = {div_quo[DVW-2:0], div_ge};
  assign div_last = div_cnt == DCW'(DVW - 1);

  assign em       = edge_sel ? e2m : e1m;
  assign estep    = edge_sel ? e2 : e1;
  assign sum_to   = (AW+1)'(f) + (AW+1)'(em);
  assign to       = (sum_to >= m_w) ? AW'(sum_to - m_w) : AW'(sum_to);
  assign r0       = (m == MW'(1)) ? '0 : AW'(1);
  assign upd      = cand_r < lr_rdata;
  assign enq      = upd && !fl_rdata && (qcnt != (AW+1)'(RESIDUE_MAX));
  assign sweep_end = sweep == m_last;
  assign tail_inc = (tail == AW'(RESIDUE_MAX - 1)) ? '0 : tail + AW'(1);
  assign head_inc = (head == AW'(RESIDUE_MAX - 1)) ? '0 : head + AW'(1);
  assign lmx      = (AW+1)'(lm);
  assign rx       = (AW+1)'(s1_r);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = refuse ? S_RESULT : S_CLEAR;
      S_CLEAR:   if (sweep_end) state_next = S_DIV;
      S_DIV: begin
        if (div_last && div_op == DIV_FIN) state_next = S_RESULT;
        else if (div_last && div_op == DIV_LIM) state_next = S_SEED;
      end
      S_SEED:    state_next = S_POP;
      S_POP:     state_next = (qcnt == '0) ? S_SUM : S_POPW;
      S_POPW:    state_next = S_LOADF;
      S_LOADF:   state_next = S_EDGE_RD;
      S_EDGE_RD: state_next = S_EDGE_WR;
      S_EDGE_WR: state_next = edge_sel ? S_POP : S_EDGE_RD;
      S_SUM:     if (sweep_end) state_next = S_DRAIN;
      S_DRAIN:   if (!s1_v && !s2_v) state_next = S_DIV;
      S_RESULT:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    in_stall = state != S_IDLE;
    lr_we = 1'b0; lr_waddr = sweep; lr_wdata = '1;
    lr_re = 1'b0; lr_raddr = sweep;
    fl_we = 1'b0; fl_waddr = sweep; fl_wdata = 1'b0;
    fl_re = 1'b0; fl_raddr = to;
    q_we  = 1'b0; q_waddr  = tail;  q_wdata  = to_r;
    q_re  = 1'b0; q_raddr  = head;
    unique case (state)
      S_CLEAR: begin
        lr_we = 1'b1;
        fl_we = 1'b1;
      end
      S_SEED: begin
        lr_we = 1'b1; lr_waddr = r0; lr_wdata = DW'(1);
        fl_we = 1'b1; fl_waddr = r0; fl_wdata = 1'b1;
        q_we  = 1'b1; q_waddr  = '0; q_wdata  = r0;
      end
      S_POP: q_re = qcnt != '0;
      S_POPW: begin
        lr_re = 1'b1; lr_raddr = q_rdata;
        fl_we = 1'b1; fl_waddr = q_rdata;
      end
      S_EDGE_RD: begin
        lr_re = 1'b1; lr_raddr = to;
        fl_re = 1'b1;
      end
      S_EDGE_WR: begin
        lr_we = upd; lr_waddr = to_r; lr_wdata = cand_r;
        fl_we = enq; fl_waddr = to_r; fl_wdata = 1'b1;
        q_we  = enq;
      end
      S_SUM: lr_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
    end else begin
      state <= state_next;
      s1_v  <= state == S_SUM;
      s2_v  <= s1_v;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_RESULT && (!out_valid || !out_stall)) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    div_cnt <= div_cnt + DCW'(1);
    div_rem <= rem_next;
    div_quo <= quo_next;
    s1_r    <= sweep;
    unique case (state)
      S_IDLE: begin
        m      <= smin;
        e1     <= sb1;
        e2     <= sc1;
        lim    <= limit;
        m_w    <= (AW+1)'(smin);
        m_last <= AW'(smin - MW'(1));
        sweep  <= '0;
        total  <= '0;
      end
      S_CLEAR: begin
        sweep <= sweep + AW'(1);
        if (sweep_end) begin
          div_op  <= DIV_E1;
          div_cnt <= '0;
          div_rem <= '0;
          div_quo <= DVW'(e1);
        end
      end
      S_DIV: begin
        if (div_last) begin
          div_cnt <= '0;
          div_rem <= '0;
          unique case (div_op)
            DIV_E1: begin
              e1m     <= AW'(rem_next);
              div_op  <= DIV_E2;
              div_quo <= DVW'(e2);
            end
            DIV_E2: begin
              e2m     <= AW'(rem_next);
              div_op  <= DIV_LIM;
              div_quo <= DVW'(lim);
            end
            DIV_LIM: lm <= AW'(rem_next);
            DIV_FIN: total <= LW'(quo_next) + LW'(acc_cnt);
          endcase
        end
      end
      S_SEED: begin
        head <= '0;
        tail <= AW'(1);
        qcnt <= (AW+1)'(1);
      end
      S_POP: begin
        sweep   <= '0;
        acc_cnt <= '0;
        acc_s   <= '0;
        acc_r   <= '0;
        if (qcnt != '0) begin
          head <= head_inc;
          qcnt <= qcnt - (AW+1)'(1);
        end
      end
      S_POPW: f <= q_rdata;
      S_LOADF: begin
        dist_f   <= lr_rdata;
        edge_sel <= 1'b0;
      end
      S_EDGE_RD: begin
        to_r   <= to;
        cand_r <= dist_f + DW'(estep);
      end
      S_EDGE_WR: begin
        edge_sel <= 1'b1;
        if (enq) begin
          tail <= tail_inc;
          qcnt <= qcnt + (AW+1)'(1);
        end
      end
      S_SUM: sweep <= sweep + AW'(1);
      S_DRAIN: begin
        if (!s1_v && !s2_v) begin
          div_op  <= DIV_FIN;
          div_cnt <= '0;
          div_rem <= '0;
          div_quo <= acc_s - DVW'(acc_r);
        end
      end
      S_RESULT: if (!out_valid || !out_stall) reach_count <= total;
      default: ;
    endcase

    // Summing pipeline: classify the entry, then accumulate.
    // The remainder of (limit - least) is (limit mod m - residue) mod m.
    s2_hit  <= (lr_rdata != '1) && (lr_rdata <= {{(DW-LW){1'b0}}, lim});
    s2_diff <= lim - lr_rdata[LW-1:0];
    s2_rem  <= (lmx >= rx) ? AW'(lmx - rx) : AW'(lmx + m_w - rx);
    if (s2_v && s2_hit) begin
      acc_cnt <= acc_cnt + (AW+1)'(1);
      acc_s   <= acc_s + DVW'(s2_diff);
      acc_r   <= acc_r + RW'(s2_rem);
    end
  end

endmodule

`default_nettype wire

/* src/rspc_ram.sv */
// ----------------------------------------------------------------------------
// rspc_ram
// Simple dual port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/rspc_checker.sv */
// ----------------------------------------------------------------------------
// rspc_checker
// Port-level checks for the reach counter, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rspc_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic [rspc_pkg::LW-1:0] limit,
  input wire logic [rspc_pkg::MW-1:0] step_one,
  input wire logic [rspc_pkg::MW-1:0] step_two,
  input wire logic [rspc_pkg::MW-1:0] step_three,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [rspc_pkg::LW-1:0] reach_count
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reach_count))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // One request at a time: busy right after acceptance.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Zero step answers zero (checked while out_valid is low and limit is nonzero).
  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (step_one == '0 || step_two == '0 || step_three == '0)
      && !out_valid && (limit != '0) |=> ##1 (reach_count == '0) && out_valid)
    else $error("refused request not zero");

endmodule

bind residue_shortest_path_reach_count rspc_checker u_rspc_checker (.*);

`default_nettype wire

/* tb/tb_residue_shortest_path_reach_count.sv */
// ----------------------------------------------------------------------------
// tb_residue_shortest_path_reach_count
// Drives limit/step requests into the reach counter with random gaps and
// output stalls, predicts each count by a residue shortest path search and
// checks every result in order against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

class reach_scoreboard;
  localparam int RMAX = 131072;
  localparam longint unsigned UNREACHED = 64'hFFFF_FFFF_FFFF_FFFF;

  longint unsigned least[RMAX];
  bit              queued[RMAX];
  int unsigned     fifo[$];
  logic [59:0]     counts_due[$];
  int              errors;
  int              checked;

  function void relax(int unsigned from, longint unsigned step, longint unsigned m);
    int unsigned     to;
    longint unsigned cand;
    to   = int'((from + step) % m);
    cand = least[from] + step;
    if (cand < least[to]) begin
      least[to] = cand;
      if (!queued[to]) begin
        fifo.push_back(to);
        queued[to] = 1'b1;
      end
    end
  endfunction

  function logic [59:0] count_reachable(logic [59:0] lim, logic [17:0] a,
                                        logic [17:0] b, logic [17:0] c);
    longint unsigned m, e1, e2, t, total, d, limv;
    int unsigned     f;
    limv = 64'(lim);
    if (a == 0 || b == 0 || c == 0) return '0;
    m = 64'(a); e1 = 64'(b); e2 = 64'(c);
    if (e1 < m) begin t = m; m = e1; e1 = t; end
    if (e2 < m) begin t = m; m = e2; e2 = t; end
    if (m > RMAX) return '0;
    for (int i = 0; i < m; i++) begin
      least[i]  = UNREACHED;
      queued[i] = 1'b0;
    end
    fifo.delete();
    f = int'(1 % m);
    least[f]  = 64'd1;
    queued[f] = 1'b1;
    fifo.push_back(f);
    while (fifo.size() > 0) begin
      f = fifo.pop_front();
      queued[f] = 1'b0;
      relax(f, e1, m);
      relax(f, e2, m);
    end
    total = 0;
    for (int i = 0; i < m; i++) begin
      d = least[i];
      if (d != UNREACHED && d <= limv) total += (limv - d) / m + 1;
    end
    return total[59:0];
  endfunction

  function void note_request(logic [59:0] lim, logic [17:0] a, logic [17:0] b,
                             logic [17:0] c);
    counts_due.push_back(count_reachable(lim, a, b, c));
  endfunction

  function void check_count(logic [59:0] got);
    logic [59:0] want;
    if (counts_due.size() == 0) begin
      $display("%0t: unexpected result reach_count=%0d", $time, got);
      errors++;
      return;
    end
    want = counts_due.pop_front();
    checked++;
    if (got !== want) begin
      $display("%0t: reach_count mismatch expected=%0d actual=%0d", $time, want, got);
      errors++;
    end
  endfunction

  function int pending();
    return counts_due.size();
  endfunction
endclass

module tb_residue_shortest_path_reach_count;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [59:0] limit = '0;
  logic [17:0] step_one = 18'd1;
  logic [17:0] step_two = 18'd1;
  logic [17:0] step_three = 18'd1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [59:0] reach_count;

  reach_scoreboard sb = new();
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int          sent = 0;

  always #10 clk = ~clk;

  residue_shortest_path_reach_count u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .limit(limit), .step_one(step_one), .step_two(step_two), .step_three(step_three),
    .out_valid(out_valid), .out_stall(out_stall), .reach_count(reach_count)
  );

  // result side: check on acceptance, then draw the next stall stretch
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_count(reach_count);
        stall_left = quiet ? 0 : $urandom_range(0, 10);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_request(logic [59:0] lim, logic [17:0] a, logic [17:0] b,
                              logic [17:0] c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    limit <= lim; step_one <= a; step_two <= b; step_three <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(lim, a, b, c);
    sent++;
  endtask

  task automatic send_random();
    logic [17:0] m, x, y;
    logic [59:0] lim;
    int          pick;
    if ($urandom_range(0, 9) == 0) m = 18'($urandom_range(1, 3000));
    else m = 18'($urandom_range(1, 64));
    x = 18'($urandom_range(m, 131072));
    y = ($urandom_range(0, 3) == 0) ? 18'($urandom_range(m, m + 40))
                                    : 18'($urandom_range(m, 131072));
    case ($urandom_range(0, 2))
      0: lim = 60'($urandom_range(1, 2000));
      1: lim = 60'($urandom_range(1, 32'hFFFF_FFFF));
      default: lim = 60'({$urandom, $urandom});
    endcase
    if (lim == 0) lim = 60'd1;
    pick = $urandom_range(0, 2);
    case (pick)
      0: send_request(lim, m, x, y);
      1: send_request(lim, x, m, y);
      default: send_request(lim, y, x, m);
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes and special cases
    send_request(60'd1, 18'd1, 18'd1, 18'd1);
    send_request({60{1'b1}}, 18'd1, 18'd5, 18'd7);
    send_request(60'd0, 18'd3, 18'd5, 18'd7);
    send_request(60'd100, 18'd0, 18'd5, 18'd7);
    send_request(60'd100, 18'd5, 18'd0, 18'd7);
    send_request(60'd100, 18'd5, 18'd7, 18'd0);
    send_request(60'd100, 18'd200000, 18'd200000, 18'd200000);
    send_request({60{1'b1}}, 18'd131072, 18'd131072, 18'd131072);
    send_request({60{1'b1}}, 18'd131071, 18'd131072, 18'd131071);
    send_request(60'd1, 18'd2, 18'd3, 18'd4);
    send_request(60'd50, 18'd4, 18'd6, 18'd8);
    send_request(60'd1000, 18'd7, 18'd3, 18'd5);
    send_request(60'd1000, 18'd9, 18'd12, 18'd6);
    send_request({60{1'b1}}, 18'd2, 18'd131072, 18'd131071);
    send_request(60'h555_5555_5555_5555, 18'd43690, 18'd87381, 18'd131071);
    send_request(60'hAAA_AAAA_AAAA_AAAA, 18'd21845, 18'd21845, 18'd43690);
    send_request(60'd17, 18'd1, 18'd131072, 18'd2);

    // hold off until the block has drained everything
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);

    for (int i = 0; i < 100; i++) begin
      quiet = (i >= 40 && i < 55);
      send_random();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests, checked %0d counts (special cases, extreme steps,",
             sent, sb.checked);
    $display("random limits and step orders with random gaps and stalls).");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** residue_shortest_path_reach_count: PASSED **");
    else
      $display("** residue_shortest_path_reach_count: FAILED **");
    $finish;
  end

  initial begin
    #400ms;
    $display("Timeout with %0d counts outstanding", sb.pending());
    $display("** residue_shortest_path_reach_count: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire
